FILE: design/indexed_list_insert_remove_search_macros.svh
// Assertion macros used by the list datapath RTL.
`ifndef INDEXED_LIST_INSERT_REMOVE_SEARCH_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_SEARCH_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ILIRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define ILIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ilirs_pkg.sv
package ilirs_pkg;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_CLEAR    = 2'd3
  } ilirs_mode_e;

  // result status codes
  typedef enum logic [1:0] {
    RES_DONE  = 2'd0,
    RES_RANGE = 2'd1,
    RES_FULL  = 2'd2
  } ilirs_res_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS,
    S_PUT,
    S_REM,
    S_SRCH,
    S_FIN
  } ilirs_state_e;

  // memory read address source
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_CNT_M1,
    RD_POS_P1,
    RD_PTR_M2,
    RD_PTR_P1,
    RD_PTR_P2
  } ilirs_rd_e;

  // walk pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT,
    PTR_POS,
    PTR_ZERO,
    PTR_DEC,
    PTR_INC
  } ilirs_ptr_e;

  // memory write source
  typedef enum logic {
    WR_SHIFT,
    WR_VAL
  } ilirs_wr_e;

  // entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } ilirs_cnt_e;

  // controller -> datapath
  typedef struct packed {
    logic       latch_in;
    logic       status_set;
    ilirs_res_e status_code;
    logic       found_ld;
    ilirs_rd_e  rd_sel;
    ilirs_ptr_e ptr_op;
    logic       wr_en;
    ilirs_wr_e  wr_sel;
    ilirs_cnt_e cnt_op;
    logic       out_load;
  } ilirs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    ilirs_mode_e mode;
    logic        pos_gt_cnt;
    logic        pos_ge_cnt;
    logic        full;
    logic        cnt_zero;
    logic        ins_at_end;
    logic        rem_at_end;
    logic        ins_last;
    logic        rem_last;
    logic        srch_match;
    logic        srch_last;
    logic        out_free;
  } ilirs_sts_t;

endpackage

FILE: design/ilirs_in_if.sv
// Request channel: one operation word.
interface ilirs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [6:0]        position;
  logic signed [31:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

FILE: design/ilirs_out_if.sv
// Response channel: one result word.
interface ilirs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [6:0] count;
  logic       empty_res;

  modport source (output valid, output status, output found, output count, output empty_res,
                  input ready);
  modport sink   (input valid, input status, input found, input count, input empty_res,
                  output ready);
endinterface

FILE: design/ilirs_ctrl.sv
module ilirs_ctrl
  import ilirs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ilirs_sts_t sts_i,
  output ilirs_cmd_t cmd_o
);

  ilirs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.pos_gt_cnt || sts_i.full || sts_i.ins_at_end) state_d = S_FIN;
            else state_d = S_INS;
          end
          MODE_REMOVE: begin
            if (sts_i.pos_ge_cnt || sts_i.rem_at_end) state_d = S_FIN;
            else state_d = S_REM;
          end
          MODE_CONTAINS: begin
            if (sts_i.cnt_zero) state_d = S_FIN;
            else state_d = S_SRCH;
          end
          MODE_CLEAR: state_d = S_FIN;
        endcase
      end
      S_INS: begin
        if (sts_i.ins_last) state_d = S_PUT;
      end
      S_PUT: state_d = S_FIN;
      S_REM: begin
        if (sts_i.rem_last) state_d = S_FIN;
      end
      S_SRCH: begin
        if (sts_i.srch_match || sts_i.srch_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      S_DECODE: begin
        unique case (sts_i.mode)
          MODE_INSERT: begin
            priority if (sts_i.pos_gt_cnt) begin
              cmd_o.status_set  = 1'b1;
              cmd_o.status_code = RES_RANGE;
            end else if (sts_i.full) begin
              cmd_o.status_set  = 1'b1;
              cmd_o.status_code = RES_FULL;
            end else if (sts_i.ins_at_end) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WR_VAL;
              cmd_o.cnt_op = CNT_INC;
            end else begin
              cmd_o.rd_sel = RD_CNT_M1;
              cmd_o.ptr_op = PTR_CNT;
            end
          end
          MODE_REMOVE: begin
            priority if (sts_i.pos_ge_cnt) begin
              cmd_o.status_set  = 1'b1;
              cmd_o.status_code = RES_RANGE;
            end else if (sts_i.rem_at_end) begin
              cmd_o.cnt_op = CNT_DEC;
            end else begin
              cmd_o.rd_sel = RD_POS_P1;
              cmd_o.ptr_op = PTR_POS;
            end
          end
          MODE_CONTAINS: begin
            cmd_o.rd_sel = RD_ZERO;
            cmd_o.ptr_op = PTR_ZERO;
          end
          MODE_CLEAR: cmd_o.cnt_op = CNT_CLR;
        endcase
      end
      S_INS: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        if (!sts_i.ins_last) begin
          cmd_o.rd_sel = RD_PTR_M2;
          cmd_o.ptr_op = PTR_DEC;
        end
      end
      S_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_VAL;
        cmd_o.cnt_op = CNT_INC;
      end
      S_REM: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        if (sts_i.rem_last) begin
          cmd_o.cnt_op = CNT_DEC;
        end else begin
          cmd_o.rd_sel = RD_PTR_P2;
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_SRCH: begin
        if (sts_i.srch_match || sts_i.srch_last) begin
          cmd_o.found_ld = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_PTR_P1;
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_FIN: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: design/ilirs_dpath.sv
module ilirs_dpath
  import ilirs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  input  ilirs_cmd_t         cmd_i,
  output ilirs_sts_t         sts_o,
  ilirs_out_if.source        out_o
);

  `include "indexed_list_insert_remove_search_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 7) ? CW : 7;

  logic [WIDTH-1:0] mem [DEPTH];

  logic [1:0]       mode_q;
  logic [6:0]       pos_q;
  logic [WIDTH-1:0] val_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [WIDTH-1:0] rd_q;
  ilirs_res_e       status_q;
  logic             found_q;
  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic             out_found_q;
  logic [6:0]       out_count_q;
  logic             out_empty_q;

  logic [63:0]      val_ext;
  logic [MW-1:0]    pos_m, cnt_m, ptr_m, raddr_m;
  logic [AW-1:0]    raddr, waddr;
  logic [WIDTH-1:0] wdata;
  logic             match;

  assign val_ext = {32'b0, value_i};
  assign pos_m   = MW'(pos_q);
  assign cnt_m   = MW'(cnt_q);
  assign ptr_m   = MW'(ptr_q);
  assign match   = (rd_q == val_q);

  // operation word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= val_ext[WIDTH-1:0];
    end
  end

  // read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:   raddr_m = '0;
      RD_CNT_M1: raddr_m = cnt_m - MW'(1);
      RD_POS_P1: raddr_m = pos_m + MW'(1);
      RD_PTR_M2: raddr_m = ptr_m - MW'(2);
      RD_PTR_P1: raddr_m = ptr_m + MW'(1);
      RD_PTR_P2: raddr_m = ptr_m + MW'(2);
      default:   raddr_m = '0;
    endcase
  end
  assign raddr = raddr_m[AW-1:0];

  // write port
  assign waddr = (cmd_i.wr_sel == WR_VAL) ? pos_m[AW-1:0] : ptr_q;
  assign wdata = (cmd_i.wr_sel == WR_VAL) ? val_q : rd_q;

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // walk pointer
  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_CNT:  ptr_d = cnt_m[AW-1:0];
      PTR_POS:  ptr_d = pos_m[AW-1:0];
      PTR_ZERO: ptr_d = '0;
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      PTR_INC:  ptr_d = ptr_q + AW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  // entry count
  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CW'(1);
      CNT_DEC:  cnt_d = cnt_q - CW'(1);
      CNT_CLR:  cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // per-operation status and found flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      status_q <= RES_DONE;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.status_set) status_q <= cmd_i.status_code;
      if (cmd_i.found_ld)   found_q  <= match;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_count_q  <= cnt_m[6:0];
      out_empty_q  <= (cnt_q == '0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.found     = out_found_q;
  assign out_o.count     = out_count_q;
  assign out_o.empty_res = out_empty_q;

  // status to controller
  assign sts_o.mode       = ilirs_mode_e'(mode_q);
  assign sts_o.pos_gt_cnt = (pos_m > cnt_m);
  assign sts_o.pos_ge_cnt = (pos_m >= cnt_m);
  assign sts_o.full       = (cnt_m == MW'(DEPTH));
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.ins_at_end = (pos_m == cnt_m);
  assign sts_o.rem_at_end = (pos_m + MW'(1) == cnt_m);
  assign sts_o.ins_last   = (ptr_m == pos_m + MW'(1));
  assign sts_o.rem_last   = (ptr_m + MW'(2) == cnt_m);
  assign sts_o.srch_match = match;
  assign sts_o.srch_last  = (ptr_m + MW'(1) == cnt_m);
  assign sts_o.out_free   = !out_valid_q || out_o.ready;

  // checks
  `ILIRS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_m <= MW'(DEPTH), "entry count above depth")
  `ILIRS_ASSERT_NOW(a_inc_not_full, cmd_i.cnt_op == CNT_INC, !sts_o.full, "insert into full list")
  `ILIRS_ASSERT_NOW(a_wr_in_list, cmd_i.wr_en, MW'(waddr) <= cnt_m, "write beyond list end")
  `ILIRS_ASSERT_NOW(a_load_free, cmd_i.out_load, !out_valid_q || out_o.ready, "result overwritten")

endmodule

FILE: design/indexed_list_insert_remove_search.sv
// Channel   Dir  Handshake     Word
// in_ch_i   in   valid/ready   mode[1:0], position[6:0], value[31:0] signed
// out_ch_o  out  valid/ready   status[1:0], found, count[6:0], empty_res
//
// Clear and out-of-range requests end without a memory walk, as do appends and removes
// of the last entry; other inserts and removes walk the entries from the list end or the
// position, and contains walks from entry 0 until a match or the end, one entry per cycle.
// One operation at a time; a new word is taken while the last result waits.
// Reset (rst_ni low, async) empties the list; entry contents are not cleared.
// A stalled result holds the controller in its final state until taken.
module indexed_list_insert_remove_search
  import ilirs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilirs_in_if.sink    in_ch_i,
  ilirs_out_if.source out_ch_o
);

  ilirs_cmd_t cmd;
  ilirs_sts_t sts;
  logic       in_ready;

  assign in_ch_i.ready = in_ready;

  ilirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ilirs_dpath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (in_ch_i.mode),
    .position_i (in_ch_i.position),
    .value_i    (in_ch_i.value),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_ch_o)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ilirs_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int SETTLE_CYCLES = 80;

  // expected result word
  typedef struct packed {
    ilirs_res_e status;
    logic       found;
    logic [6:0] count;
    logic       empty_res;
  } list_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ilirs_in_if  req_if ();
  ilirs_out_if rsp_if ();

  indexed_list_insert_remove_search #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(32)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (req_if.sink),
    .out_ch_o(rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the list
  logic [31:0] list_mem [LIST_DEPTH];
  int          list_len = 0;

  list_res_t   pending_res_q[$];
  int          err_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_req = 0;

  // apply one operation to the shadow list, return the result it gives
  function automatic list_res_t list_apply(ilirs_mode_e op, logic [6:0] pos,
                                           logic [31:0] val);
    list_res_t res;
    res.status = RES_DONE;
    res.found  = 1'b0;
    case (op)
      MODE_INSERT: begin
        if (int'(pos) > list_len) begin
          res.status = RES_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = RES_FULL;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (int'(pos) >= list_len) begin
          res.status = RES_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      MODE_CONTAINS: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) res.found = 1'b1;
        end
      end
      default: list_len = 0;
    endcase
    res.count     = 7'(list_len);
    res.empty_res = (list_len == 0);
    return res;
  endfunction

  // lower valid in this step, then wait for a clock edge
  task automatic idle_request();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one word, wait for the accept, queue its predicted result
  task automatic send_word(ilirs_mode_e op, logic [6:0] pos, logic [31:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      idle_request();
      repeat (gap - 1) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    pending_res_q.push_back(list_apply(op, pos, val));
  endtask

  // hold the request side until every pending result is back
  task automatic wait_drain();
    idle_request();
    while (pending_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // random word, mostly in range, values biased toward held ones
  task automatic pick_word(int ins_w, int rem_w, int clr_w, output ilirs_mode_e op,
                           output logic [6:0] pos, output logic [31:0] val);
    int r;
    int k;
    r = $urandom_range(99);
    if (r < ins_w) op = MODE_INSERT;
    else if (r < ins_w + rem_w) op = MODE_REMOVE;
    else if (r < 100 - clr_w) op = MODE_CONTAINS;
    else op = MODE_CLEAR;

    k = $urandom_range(9);
    if (k <= 3) begin
      val = $urandom;
    end else if (k <= 5) begin
      val = 32'($urandom_range(15)) - 32'd8;
    end else if (k == 6) begin
      case ($urandom_range(3))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'h0000_0000;
        default: val = 32'hffff_ffff;
      endcase
    end else if (list_len > 0) begin
      val = list_mem[$urandom_range(list_len - 1)];
    end else begin
      val = $urandom;
    end

    if ($urandom_range(99) < 15) begin
      pos = 7'($urandom_range(127));
    end else if (op == MODE_INSERT) begin
      case ($urandom_range(3))
        0: pos = 7'd0;
        1: pos = 7'(list_len);
        default: pos = 7'($urandom_range(list_len));
      endcase
    end else if (list_len > 0) begin
      pos = 7'($urandom_range(list_len - 1));
    end else begin
      pos = 7'd0;
    end
  endtask

  // operations on an empty list
  task automatic test_empty_list();
    send_word(MODE_CONTAINS, 7'd0, 32'd0);
    send_word(MODE_REMOVE, 7'd0, 32'd0);
    send_word(MODE_INSERT, 7'd1, 32'd5);
    send_word(MODE_INSERT, 7'd127, 32'hffff_ffff);
    send_word(MODE_CLEAR, 7'd0, 32'd0);
    wait_drain();
  endtask

  // inserts and removes at both ends and the middle, value extremes
  task automatic test_insert_remove_edges();
    send_word(MODE_INSERT, 7'd0, 32'h7fff_ffff);
    send_word(MODE_INSERT, 7'd1, 32'h8000_0000);
    send_word(MODE_INSERT, 7'd1, 32'h0000_0000);
    send_word(MODE_INSERT, 7'd0, 32'hffff_ffff);
    send_word(MODE_CONTAINS, 7'd0, 32'h8000_0000);
    send_word(MODE_CONTAINS, 7'd0, 32'hffff_ffff);
    send_word(MODE_CONTAINS, 7'd0, 32'd12345);
    send_word(MODE_INSERT, 7'd5, 32'd1);
    send_word(MODE_REMOVE, 7'd4, 32'd0);
    send_word(MODE_REMOVE, 7'd2, 32'd0);
    send_word(MODE_REMOVE, 7'd2, 32'd0);
    send_word(MODE_REMOVE, 7'd0, 32'd0);
    send_word(MODE_CONTAINS, 7'd0, 32'h7fff_ffff);
    send_word(MODE_REMOVE, 7'd0, 32'd0);
    send_word(MODE_REMOVE, 7'd0, 32'd0);
    wait_drain();
  endtask

  // fill to capacity, then refused and out-of-range inserts
  task automatic test_full_list();
    logic [31:0] v;
    send_word(MODE_CLEAR, 7'd0, 32'd0);
    while (list_len < LIST_DEPTH) begin
      v = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom;
      send_word(MODE_INSERT, 7'($urandom_range(list_len)), v);
    end
    send_word(MODE_INSERT, 7'd10, 32'd1);
    send_word(MODE_INSERT, 7'd64, 32'd1);
    send_word(MODE_INSERT, 7'd65, 32'd1);
    send_word(MODE_INSERT, 7'd127, 32'd1);
    send_word(MODE_CONTAINS, 7'd0, list_mem[LIST_DEPTH-1]);
    send_word(MODE_REMOVE, 7'd64, 32'd0);
    send_word(MODE_REMOVE, 7'd63, 32'd0);
    send_word(MODE_INSERT, 7'd63, 32'h8000_0000);
    send_word(MODE_REMOVE, 7'd0, 32'd0);
    send_word(MODE_CLEAR, 7'd0, 32'd0);
    wait_drain();
  endtask

  // long result stall while words keep coming
  task automatic test_backpressure();
    ilirs_mode_e op;
    logic [6:0]  pos;
    logic [31:0] val;
    set_idling(0, 0);
    rx_hold_req = 400;
    repeat (20) begin
      pick_word(60, 10, 0, op, pos, val);
      send_word(op, pos, val);
    end
    wait_drain();
  endtask

  // random traffic, cycling through growth, shrink and mixed phases every hundred words
  task automatic test_random_mix(int n_items, int tx_pct, int rx_pct);
    ilirs_mode_e op;
    logic [6:0]  pos;
    logic [31:0] val;
    set_idling(tx_pct, rx_pct);
    for (int i = 0; i < n_items; i++) begin
      case ((i / 100) % 3)
        0: pick_word(60, 12, 1, op, pos, val);
        1: pick_word(20, 50, 2, op, pos, val);
        default: pick_word(40, 25, 4, op, pos, val);
      endcase
      send_word(op, pos, val);
    end
    wait_drain();
  endtask

  // result side: check each word, drive ready
  initial begin : result_checker
    list_res_t want;
    int        hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_res_q.size() == 0) begin
          $error("unexpected result: status %0d count %0d", rsp_if.status, rsp_if.count);
          err_count++;
        end else begin
          want = pending_res_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            err_count++;
          end
          if (rsp_if.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
            err_count++;
          end
          if (rsp_if.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_if.count);
            err_count++;
          end
          if (rsp_if.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, actual %0d", want.empty_res, rsp_if.empty_res);
            err_count++;
          end
        end
      end
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // test sequence
  initial begin
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_INSERT;
    req_if.position = '0;
    req_if.value    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(8, 88);
    test_empty_list();
    test_insert_remove_edges();
    test_full_list();
    test_backpressure();
    test_random_mix(470, 8, 88);
    test_random_mix(470, 88, 8);
    test_random_mix(470, 0, 0);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_res_q.size() != 0) begin
      $error("%0d results never arrived", pending_res_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
